@@ hw/rtl/jbt_pkg.sv @@
// jbt_pkg: types, codes and character helpers for the json byte tokenizer
// no dependencies; imported by json_byte_tokenizer
`timescale 1ns / 1ps
`default_nettype none

package jbt_pkg;

  // document byte limit; the tokenizer caps it at 65535 bytes
  localparam longint unsigned JBT_MAX_DOC_BYTES = 64'd65536;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_STR    = 4'd1,
    MODE_ESC    = 4'd2,
    MODE_HEX    = 4'd3,
    MODE_NMINUS = 4'd4,
    MODE_NINT   = 4'd5,
    MODE_NDOT   = 4'd6,
    MODE_NFRAC  = 4'd7,
    MODE_NEXP   = 4'd8,
    MODE_NESIGN = 4'd9,
    MODE_NEDIG  = 4'd10,
    MODE_LIT    = 4'd11
  } mode_t;

  localparam logic [3:0] TOK_LBRACE   = 4'd0;
  localparam logic [3:0] TOK_RBRACE   = 4'd1;
  localparam logic [3:0] TOK_LBRACKET = 4'd2;
  localparam logic [3:0] TOK_RBRACKET = 4'd3;
  localparam logic [3:0] TOK_COLON    = 4'd4;
  localparam logic [3:0] TOK_COMMA    = 4'd5;
  localparam logic [3:0] TOK_STRING   = 4'd6;
  localparam logic [3:0] TOK_NUMBER   = 4'd7;
  localparam logic [3:0] TOK_BOOLEAN  = 4'd8;
  localparam logic [3:0] TOK_NULL     = 4'd9;

  localparam logic [3:0] ERR_OK           = 4'd0;
  localparam logic [3:0] ERR_STRING_BYTE  = 4'd1;
  localparam logic [3:0] ERR_ESCAPE       = 4'd2;
  localparam logic [3:0] ERR_HEX          = 4'd3;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd4;
  localparam logic [3:0] ERR_LONE_MINUS   = 4'd5;
  localparam logic [3:0] ERR_EXP_AFTER_DOT = 4'd6;
  localparam logic [3:0] ERR_LITERAL      = 4'd7;
  localparam logic [3:0] ERR_TOO_LONG     = 4'd8;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [3:0]  err;
  } res_t;

  typedef struct packed {
    res_t res;
    logic last;
  } qent_t;

  // what a byte does when no token is open
  typedef struct packed {
    mode_t      mode;
    logic       start;
    logic       is_lit;
    logic [1:0] lit;
    logic       tok;
    logic [3:0] kind;
  } idle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic idle_t idle_dec(input logic [7:0] c);
    idle_t d;
    d = '{mode: MODE_IDLE, start: 1'b0, is_lit: 1'b0, lit: LIT_TRUE, tok: 1'b0,
          kind: TOK_LBRACE};
    case (c)
      "{": begin d.tok = 1'b1; d.kind = TOK_LBRACE; end
      "}": begin d.tok = 1'b1; d.kind = TOK_RBRACE; end
      "[": begin d.tok = 1'b1; d.kind = TOK_LBRACKET; end
      "]": begin d.tok = 1'b1; d.kind = TOK_RBRACKET; end
      ":": begin d.tok = 1'b1; d.kind = TOK_COLON; end
      ",": begin d.tok = 1'b1; d.kind = TOK_COMMA; end
      "\"": begin d.mode = MODE_STR; d.start = 1'b1; end
      "-": begin d.mode = MODE_NMINUS; d.start = 1'b1; end
      "t": begin d.mode = MODE_LIT; d.start = 1'b1; d.is_lit = 1'b1; d.lit = LIT_TRUE; end
      "f": begin d.mode = MODE_LIT; d.start = 1'b1; d.is_lit = 1'b1; d.lit = LIT_FALSE; end
      "n": begin d.mode = MODE_LIT; d.start = 1'b1; d.is_lit = 1'b1; d.lit = LIT_NULL; end
      default: begin
        if (is_digit(c)) begin
          d.mode  = MODE_NINT;
          d.start = 1'b1;
        end
      end
    endcase
    return d;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [3:0] lit_tok(input logic [1:0] k);
    return (k == LIT_TRUE || k == LIT_FALSE) ? TOK_BOOLEAN : TOK_NULL;
  endfunction

  // expected character of a literal at a given index
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      LIT_TRUE: begin
        case (i)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (i)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (i)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  // length from origin through pos inclusive, saturated to 16 bits
  function automatic logic [15:0] span_len(input logic [15:0] org, input logic [15:0] pos);
    logic [16:0] l;
    l = {1'b0, pos} - {1'b0, org} + 17'd1;
    return l[16] ? 16'hFFFF : l[15:0];
  endfunction

  function automatic res_t fail_res(input mode_t m, input logic [1:0] lit,
                                    input logic [15:0] org, input logic [15:0] pos,
                                    input logic [3:0] err);
    res_t r;
    logic [3:0] kind;
    logic open;
    open = 1'b1;
    kind = TOK_LBRACE;
    case (m)
      MODE_STR, MODE_ESC, MODE_HEX: kind = TOK_STRING;
      MODE_NMINUS, MODE_NINT, MODE_NDOT, MODE_NFRAC, MODE_NEXP, MODE_NESIGN,
      MODE_NEDIG: kind = TOK_NUMBER;
      MODE_LIT: kind = lit_tok(lit);
      default: open = 1'b0;
    endcase
    if (open && pos >= org) begin
      r = '{kind: kind, start: org, len: span_len(org, pos), err: err};
    end else begin
      r = '{kind: TOK_LBRACE, start: pos, len: 16'd1, err: err};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/json_byte_tokenizer.sv @@
// json_byte_tokenizer: single-pass JSON lexer, one document byte per transaction
// depends on jbt_pkg (types, codes, character helpers)
//
// usage:
//   input channel: in_valid/in_stall carry one byte and an end-of-document flag.
//   result channel: out_valid/out_stall carry tokens (kind, start offset, length),
//   error results and a flag on the last result a byte produced.
//   each accepted byte is decoded in the cycle it is taken; its zero, one or two
//   results land in a three-entry result queue and show on the outputs from the
//   next cycle when the queue was empty, else behind the results already waiting.
//   throughput is one byte per cycle while the queue holds at most one entry;
//   in_stall rises when two or more results wait, as after a byte that yields two
//   results (one that closes a number and starts another token), or when the receiver stalls.
//   after an error, bytes are taken and dropped until the end-of-document byte.
//   the end-of-document byte flushes a pending token and returns the lexer to its
//   reset state, so the next byte is offset 0 of a new document.
//   reset (rst_n low, synchronous) empties the queue and clears the lexer.
`timescale 1ns / 1ps
`default_nettype none

module json_byte_tokenizer
  import jbt_pkg::*;
#(
  parameter longint unsigned MAX_DOC_BYTES = JBT_MAX_DOC_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_document,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic [3:0]       out_error_code,
  output logic             out_last_of_run
);

  localparam logic [15:0] DOC_LIMIT =
    (MAX_DOC_BYTES < 64'd65535) ? MAX_DOC_BYTES[15:0] : 16'hFFFF;

  // lexer state
  mode_t       mode_r, mode_nxt;
  logic [1:0]  lit_r, lit_nxt;
  logic [2:0]  mi_r, mi_nxt;
  logic [2:0]  hex_r, hex_nxt;
  logic [15:0] org_r, org_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        err_r, err_nxt;

  // result queue
  qent_t       q_r [3];
  logic [1:0]  head_r, head_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic        accept, pop;
  idle_t       idl;
  logic        is_e;
  logic [3:0]  fail_err;
  logic        close_str, lit_done, end_num, use_idle;
  logic [1:0]  k;
  logic [2:0]  mi_inc;
  logic [2:0]  hex_inc;
  logic        a_vld, b_vld, f_vld;
  res_t        a_res, b_res, f_res;
  logic [1:0]  n_res;
  qent_t       first_ent, second_ent;
  logic [1:0]  wr0, wr1;

  function automatic logic [1:0] wrap3(input logic [2:0] v);
    logic [2:0] w;
    w = (v >= 3'd3) ? v - 3'd3 : v;
    return w[1:0];
  endfunction

  assign in_stall  = (cnt_r >= 2'd2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  assign out_token_kind   = q_r[head_r].res.kind;
  assign out_token_start  = q_r[head_r].res.start;
  assign out_token_length = q_r[head_r].res.len;
  assign out_error_code   = q_r[head_r].res.err;
  assign out_last_of_run  = q_r[head_r].last;

  // byte decode: on_byte, then flush at end of document
  always_comb begin
    idl       = idle_dec(in_data_byte);
    is_e      = (in_data_byte == "e") || (in_data_byte == "E");
    k         = (lit_r == 2'd3) ? LIT_NULL : lit_r;
    mi_inc    = mi_r + 3'd1;
    hex_inc   = hex_r + 3'd1;
    mode_nxt  = mode_r;
    lit_nxt   = lit_r;
    mi_nxt    = mi_r;
    hex_nxt   = hex_r;
    org_nxt   = org_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    fail_err  = ERR_OK;
    close_str = 1'b0;
    lit_done  = 1'b0;
    end_num   = 1'b0;
    use_idle  = 1'b0;
    a_vld     = 1'b0;
    b_vld     = 1'b0;
    f_vld     = 1'b0;
    a_res     = '0;
    b_res     = '0;
    f_res     = '0;

    if (!err_r) begin
      if (pos_r >= DOC_LIMIT) begin
        a_vld    = 1'b1;
        a_res    = fail_res(mode_r, lit_r, org_r, pos_r, ERR_TOO_LONG);
        err_nxt  = 1'b1;
        mode_nxt = MODE_IDLE;
      end else begin
        case (mode_r)
          MODE_STR: begin
            if (in_data_byte == "\"") begin
              close_str = 1'b1;
              mode_nxt  = MODE_IDLE;
            end else if (in_data_byte == "\\") begin
              mode_nxt = MODE_ESC;
            end else if (!is_alpha(in_data_byte)) begin
              fail_err = ERR_STRING_BYTE;
            end
          end
          MODE_ESC: begin
            if (in_data_byte == "u") begin
              mode_nxt = MODE_HEX;
              hex_nxt  = 3'd0;
            end else if (in_data_byte == "\"" || in_data_byte == "\\" ||
                         in_data_byte == "/" || is_alpha(in_data_byte)) begin
              mode_nxt = MODE_STR;
            end else begin
              fail_err = ERR_ESCAPE;
            end
          end
          MODE_HEX: begin
            if (!is_hex(in_data_byte)) begin
              fail_err = ERR_HEX;
            end else begin
              hex_nxt = hex_inc;
              if (hex_inc >= 3'd4) mode_nxt = MODE_STR;
            end
          end
          MODE_NMINUS: begin
            if (is_digit(in_data_byte)) mode_nxt = MODE_NINT;
            else fail_err = ERR_LONE_MINUS;
          end
          MODE_NINT: begin
            if (!is_digit(in_data_byte)) begin
              if (in_data_byte == ".") mode_nxt = MODE_NDOT;
              else if (is_e) mode_nxt = MODE_NEXP;
              else end_num = 1'b1;
            end
          end
          MODE_NDOT: begin
            if (is_digit(in_data_byte)) mode_nxt = MODE_NFRAC;
            else if (is_e) fail_err = ERR_EXP_AFTER_DOT;
            else end_num = 1'b1;
          end
          MODE_NFRAC: begin
            if (!is_digit(in_data_byte)) begin
              if (is_e) mode_nxt = MODE_NEXP;
              else end_num = 1'b1;
            end
          end
          MODE_NEXP: begin
            if (in_data_byte == "+" || in_data_byte == "-") mode_nxt = MODE_NESIGN;
            else if (is_digit(in_data_byte)) mode_nxt = MODE_NEDIG;
            else end_num = 1'b1;
          end
          MODE_NESIGN, MODE_NEDIG: begin
            if (is_digit(in_data_byte)) mode_nxt = MODE_NEDIG;
            else end_num = 1'b1;
          end
          MODE_LIT: begin
            if (mi_r < lit_len(k) && in_data_byte == lit_char(k, mi_r)) begin
              mi_nxt = mi_inc;
              if (mi_inc >= lit_len(k)) begin
                lit_done = 1'b1;
                mode_nxt = MODE_IDLE;
              end
            end else begin
              fail_err = ERR_LITERAL;
            end
          end
          default: use_idle = 1'b1;
        endcase

        if (fail_err != ERR_OK) begin
          a_vld    = 1'b1;
          a_res    = fail_res(mode_r, lit_r, org_r, pos_r, fail_err);
          err_nxt  = 1'b1;
          mode_nxt = MODE_IDLE;
        end else if (close_str) begin
          a_vld = 1'b1;
          a_res = '{kind: TOK_STRING, start: org_r, len: span_len(org_r, pos_r),
                    err: ERR_OK};
        end else if (lit_done) begin
          a_vld = 1'b1;
          a_res = '{kind: lit_tok(k), start: org_r, len: {13'd0, lit_len(k)}, err: ERR_OK};
        end else if (end_num) begin
          a_vld = 1'b1;
          a_res = '{kind: TOK_NUMBER, start: org_r, len: pos_r - org_r, err: ERR_OK};
        end

        // the byte after a number is handled again as a fresh byte
        if (use_idle || end_num) begin
          mode_nxt = idl.mode;
          if (idl.start) org_nxt = pos_r;
          if (idl.is_lit) begin
            lit_nxt = idl.lit;
            mi_nxt  = 3'd1;
          end
          if (idl.tok) begin
            if (end_num) begin
              b_vld = 1'b1;
              b_res = '{kind: idl.kind, start: pos_r, len: 16'd1, err: ERR_OK};
            end else begin
              a_vld = 1'b1;
              a_res = '{kind: idl.kind, start: pos_r, len: 16'd1, err: ERR_OK};
            end
          end
        end

        pos_nxt = pos_r + 16'd1;

        if (in_end_of_document && !err_nxt) begin
          case (mode_nxt)
            MODE_STR, MODE_ESC, MODE_HEX: begin
              f_vld = 1'b1;
              f_res = fail_res(mode_nxt, lit_nxt, org_nxt, pos_r, ERR_UNTERMINATED);
            end
            MODE_NMINUS: begin
              f_vld = 1'b1;
              f_res = fail_res(mode_nxt, lit_nxt, org_nxt, pos_r, ERR_LONE_MINUS);
            end
            MODE_NINT, MODE_NDOT, MODE_NFRAC, MODE_NEXP, MODE_NESIGN, MODE_NEDIG: begin
              f_vld = 1'b1;
              f_res = '{kind: TOK_NUMBER, start: org_nxt, len: span_len(org_nxt, pos_r),
                        err: ERR_OK};
            end
            MODE_LIT: begin
              f_vld = 1'b1;
              f_res = fail_res(mode_nxt, lit_nxt, org_nxt, pos_r, ERR_LITERAL);
            end
            default: f_vld = 1'b0;
          endcase
        end
      end
    end

    if (in_end_of_document) begin
      mode_nxt = MODE_IDLE;
      lit_nxt  = 2'd0;
      mi_nxt   = 3'd0;
      hex_nxt  = 3'd0;
      org_nxt  = 16'd0;
      pos_nxt  = 16'd0;
      err_nxt  = 1'b0;
    end
  end

  // pack up to two results in order; b only exists alongside a
  always_comb begin
    n_res      = {1'b0, a_vld} + {1'b0, b_vld} + {1'b0, f_vld};
    first_ent  = '{res: (a_vld ? a_res : f_res), last: (n_res == 2'd1)};
    second_ent = '{res: (b_vld ? b_res : f_res), last: 1'b1};
    wr0        = wrap3({1'b0, head_r} + {1'b0, cnt_r});
    wr1        = wrap3({1'b0, wr0} + 3'd1);
    head_nxt   = pop ? wrap3({1'b0, head_r} + 3'd1) : head_r;
    cnt_nxt    = cnt_r - {1'b0, pop} + (accept ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      lit_r  <= 2'd0;
      mi_r   <= 3'd0;
      hex_r  <= 3'd0;
      org_r  <= 16'd0;
      pos_r  <= 16'd0;
      err_r  <= 1'b0;
      head_r <= 2'd0;
      cnt_r  <= 2'd0;
    end else begin
      if (accept) begin
        mode_r <= mode_nxt;
        lit_r  <= lit_nxt;
        mi_r   <= mi_nxt;
        hex_r  <= hex_nxt;
        org_r  <= org_nxt;
        pos_r  <= pos_nxt;
        err_r  <= err_nxt;
      end
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (n_res != 2'd0) q_r[wr0] <= first_ent;
      if (n_res == 2'd2) q_r[wr1] <= second_ent;
    end
  end

endmodule

`default_nettype wire
